[rtl/cnhd_pkg.sv]
// shared types and constants for the chained name hash directory
`default_nettype none
package cnhd_pkg;
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_BUILD  = 2'd2;
    localparam logic [1:0] CMD_LOOKUP = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_BUILT = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_BH_INIT, S_B_READ, S_B_HASH, S_B_MOD, S_B_HEAD, S_B_LINK,
        S_L_HASH, S_L_MOD, S_L_HEAD, S_L_PTR, S_L_READ, S_L_CMP, S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic cap_in;     // latch input word
        logic clr;        // empty directory
        logic app;        // store name
        logic full_resp;  // table full result
        logic nb_resp;    // not built result
        logic done_resp;  // done result
        logic nf_resp;    // not found result
        logic found_resp; // found result
        logic set_built;
        logic i_zero;     // walk index to zero
        logic i_inc;
        logic bh_init;    // write empty head at walk index
        logic rd_name;    // read entry at walk index
        logic hash_src;   // 0 input name, 1 stored name
        logic hash_go;
        logic mod_go;
        logic rd_head;    // read head at hash remainder
        logic b_link;     // write link and head
        logic l_head;     // load chain pointer from head read
        logic l_next;     // follow link
        logic l_hit;      // mark chain entry as matching
        logic l_rd;       // read name and link at chain pointer
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic built;
        logic i_last;     // walk index at count-1
        logic mod_done;
        logic ptr_end;    // chain pointer null or out of range or bound hit
        logic name_eq;    // entry read at chain pointer matches the key
        logic match;
    } t_stat;

    function automatic logic [7:0] fold(input logic [7:0] b);
        fold = (b >= 8'h61 && b <= 8'h7a) ? b - 8'h20 : b;
    endfunction
endpackage
`default_nettype wire

[rtl/chained_name_hash_directory.sv]
// Directory of up to MAX_ENTRIES 8-byte names with case-insensitive hashed
// lookup by separate chaining. One command word at a time: a lookup walks
// the chain one entry after another (the hash remainder comes from a
// bit-serial divider), and build hashes and reduces each entry in turn.
// The next command is accepted while the previous result waits; its own
// result is held back until the output word has been taken.
`default_nettype none
module chained_name_hash_directory #(
    parameter int MAX_ENTRIES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [63:0] i_name,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [11:0]      o_index
);
    import cnhd_pkg::*;
    t_cmd  c;
    t_stat st;

    cnhd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_cmd(i_cmd),
        .o_ready(o_ready), .i_out_free(!o_valid || i_ready), .i_st(st), .o_c(c)
    );

    cnhd_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_name(i_name), .i_c(c), .o_st(st),
        .i_out_ready(i_ready), .o_out_valid(o_valid), .o_status(o_status),
        .o_index(o_index)
    );

`ifndef ASSERT_OFF
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_NOT_BUILT) else $error("bad status");
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NOT_FOUND || o_status == ST_FULL ||
        o_status == ST_NOT_BUILT) |-> o_index == 12'd0) else $error("index");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("accept while busy");
`endif
endmodule
`default_nettype wire

[rtl/cnhd_ctrl.sv]
// command sequencer for the directory
`default_nettype none
module cnhd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [1:0]     i_cmd,
    output logic                o_ready,
    input  wire logic           i_out_free,
    input  wire cnhd_pkg::t_stat i_st,
    output cnhd_pkg::t_cmd      o_c
);
    import cnhd_pkg::*;
    t_state r_state, n_state;
    logic [1:0] r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
        if (o_ready && i_valid) r_cmd <= i_cmd;
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) begin
                case (i_cmd)
                    CMD_BUILD:  n_state = S_BH_INIT;
                    CMD_LOOKUP: n_state = S_L_HASH;
                    default:    n_state = S_RESP;
                endcase
            end
            S_BH_INIT: n_state = (i_st.empty || i_st.i_last) ?
                                 (i_st.empty ? S_RESP : S_B_READ) : S_BH_INIT;
            S_B_READ: n_state = S_B_HASH;
            S_B_HASH: n_state = S_B_MOD;
            S_B_MOD:  if (i_st.mod_done) n_state = S_B_HEAD;
            S_B_HEAD: n_state = S_B_LINK;
            S_B_LINK: n_state = i_st.i_last ? S_RESP : S_B_READ;
            S_L_HASH: n_state = (!i_st.built || i_st.empty) ? S_RESP : S_L_MOD;
            S_L_MOD:  if (i_st.mod_done) n_state = S_L_HEAD;
            S_L_HEAD: n_state = S_L_PTR;
            S_L_PTR:  n_state = S_L_READ;
            S_L_READ: n_state = i_st.ptr_end ? S_RESP : S_L_CMP;
            S_L_CMP:  n_state = i_st.name_eq ? S_RESP : S_L_READ;
            // result waits here until the output word is free
            S_RESP:   if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_c = '0;
        case (r_state)
            S_IDLE: begin
                o_c.cap_in = o_ready && i_valid;
                o_c.i_zero = 1'b1;
            end
            S_BH_INIT: begin
                o_c.bh_init = !i_st.empty;
                o_c.i_inc = !i_st.i_last;
                o_c.i_zero = i_st.i_last;
            end
            S_B_READ: o_c.rd_name = 1'b1;
            S_B_HASH: begin o_c.hash_src = 1'b1; o_c.hash_go = 1'b1; end
            S_B_MOD: o_c.mod_go = 1'b1;
            S_B_HEAD: o_c.rd_head = 1'b1;
            S_B_LINK: begin o_c.b_link = 1'b1; o_c.i_inc = 1'b1; end
            S_L_HASH: o_c.hash_go = 1'b1;
            S_L_MOD: o_c.mod_go = 1'b1;
            S_L_HEAD: o_c.rd_head = 1'b1;
            S_L_PTR: o_c.l_head = 1'b1;
            S_L_READ: o_c.l_rd = 1'b1;
            S_L_CMP: begin
                o_c.l_hit = i_st.name_eq;
                o_c.l_next = !i_st.name_eq;
            end
            S_RESP: if (i_out_free) begin
                case (r_cmd)
                    CMD_CLEAR: begin o_c.clr = 1'b1; o_c.done_resp = 1'b1; end
                    CMD_APPEND: begin
                        if (i_st.full) o_c.full_resp = 1'b1;
                        else begin o_c.app = 1'b1; o_c.done_resp = 1'b1; end
                    end
                    CMD_BUILD: begin o_c.set_built = 1'b1; o_c.done_resp = 1'b1; end
                    default: begin
                        if (!i_st.built) o_c.nb_resp = 1'b1;
                        else if (i_st.match && !i_st.empty) o_c.found_resp = 1'b1;
                        else o_c.nf_resp = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

[rtl/cnhd_dp.sv]
// directory storage, hash, remainder unit and result register
`default_nettype none
module cnhd_dp #(
    parameter int MAX_ENTRIES = 4096
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [63:0]     i_name,
    input  wire cnhd_pkg::t_cmd  i_c,
    output cnhd_pkg::t_stat      o_st,
    input  wire logic            i_out_ready,
    output logic                 o_out_valid,
    output logic [2:0]           o_status,
    output logic [11:0]          o_index
);
    import cnhd_pkg::*;
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = AW + 1;
    localparam int HW = 32;
    localparam logic [CW-1:0] CMAX = CW'(MAX_ENTRIES);

    logic [63:0]   r_names [MAX_ENTRIES];
    logic [CW-1:0] r_links [MAX_ENTRIES];
    logic [CW-1:0] r_heads [MAX_ENTRIES];
    logic [CW-1:0] r_count;
    logic          r_built;
    logic [63:0]   r_key;
    logic [CW-1:0] r_i;
    logic [63:0]   r_rd_name;
    logic [CW-1:0] r_rd_link;
    logic [CW-1:0] r_rd_head;
    logic [HW-1:0] r_hash;
    logic [HW-1:0] r_rem;
    logic [5:0]    r_bit;
    logic          r_mod_busy, r_mod_done;
    logic [CW-1:0] r_ptr;
    logic [CW-1:0] r_steps;
    logic          r_match;
    logic [2:0]    r_status;
    logic [11:0]   r_index;
    logic [CW-1:0] nul;

    assign nul = '1;

    function automatic logic [HW-1:0] hash_of(input logic [63:0] w);
        logic [HW-1:0] h;
        logic stop;
        h = HW'(fold(w[7:0]));
        stop = 1'b0;
        for (int k = 1; k < 8; k++) begin
            if (fold(w[8*k +: 8]) == 8'd0) stop = 1'b1;
            if (!stop) h = ((k == 1) ? h * 3 : h << 1) + HW'(fold(w[8*k +: 8]));
        end
        return h;
    endfunction

    function automatic logic names_eq(input logic [63:0] a, input logic [63:0] b);
        logic r, stop;
        r = 1'b1;
        stop = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (!stop) begin
                if (fold(a[8*k +: 8]) != fold(b[8*k +: 8])) begin
                    r = 1'b0; stop = 1'b1;
                end else if (fold(a[8*k +: 8]) == 8'd0) stop = 1'b1;
            end
        end
        return r;
    endfunction

    // restoring remainder, one bit a cycle
    logic [HW:0] rem_sh;
    assign rem_sh = {r_rem, r_hash[r_bit[4:0]]};

    always_ff @(posedge i_clk) begin
        if (i_c.cap_in) r_key <= i_name;
        if (i_c.i_zero) r_i <= '0;
        else if (i_c.i_inc) r_i <= r_i + 1'b1;
        // one head write port: empty mark during init, new head during build
        if (i_c.bh_init || i_c.b_link)
            r_heads[i_c.bh_init ? r_i[AW-1:0] : r_rem[AW-1:0]] <=
                i_c.bh_init ? nul : r_i;
        if (i_c.rd_name) r_rd_name <= r_names[r_i[AW-1:0]];
        if (i_c.hash_go) r_hash <= hash_of(i_c.hash_src ? r_rd_name : r_key);
        if (i_c.rd_head) r_rd_head <= r_heads[r_rem[AW-1:0]];
        if (i_c.b_link) r_links[r_i[AW-1:0]] <= r_rd_head;
        if (i_c.app) r_names[r_count[AW-1:0]] <= r_key;
        if (i_c.l_head) begin
            r_ptr <= r_rd_head;
            r_steps <= '0;
        end else if (i_c.l_next) begin
            r_ptr <= r_rd_link;
            r_steps <= r_steps + 1'b1;
        end
        if (i_c.l_rd) begin
            r_rd_name <= r_names[r_ptr[AW-1:0]];
            r_rd_link <= r_links[r_ptr[AW-1:0]];
        end
        if (i_c.hash_go) r_match <= 1'b0;
        else if (i_c.l_hit) r_match <= 1'b1;
        if (i_c.found_resp) r_index <= 12'(r_ptr);
        else if (i_c.app) r_index <= 12'(r_count);
        else if (i_c.done_resp || i_c.nf_resp || i_c.full_resp || i_c.nb_resp)
            r_index <= '0;
        if (i_c.done_resp) r_status <= ST_DONE;
        if (i_c.found_resp) r_status <= ST_FOUND;
        if (i_c.nf_resp) r_status <= ST_NOT_FOUND;
        if (i_c.full_resp) r_status <= ST_FULL;
        if (i_c.nb_resp) r_status <= ST_NOT_BUILT;
        if (i_c.hash_go) begin
            r_rem <= '0;
            r_bit <= 6'd31;
        end else if (r_mod_busy) begin
            r_rem <= (rem_sh >= (HW+1)'(r_count)) ? HW'(rem_sh - (HW+1)'(r_count))
                                                  : rem_sh[HW-1:0];
            r_bit <= r_bit - 1'b1;
        end
        if (!i_rst_n) begin
            r_count <= '0;
            r_built <= 1'b0;
            o_out_valid <= 1'b0;
            r_mod_busy <= 1'b0;
            r_mod_done <= 1'b0;
        end else begin
            if (i_c.clr) begin r_count <= '0; r_built <= 1'b0; end
            if (i_c.app) begin r_count <= r_count + 1'b1; r_built <= 1'b0; end
            if (i_c.set_built) r_built <= 1'b1;
            if (i_c.done_resp || i_c.found_resp || i_c.nf_resp || i_c.full_resp
                || i_c.nb_resp) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
            if (i_c.hash_go) begin r_mod_busy <= 1'b1; r_mod_done <= 1'b0; end
            else if (r_mod_busy && r_bit == 6'd0) begin
                r_mod_busy <= 1'b0; r_mod_done <= 1'b1;
            end else if (i_c.mod_go && r_mod_done) r_mod_done <= 1'b0;
        end
    end

    assign o_st.full     = (r_count >= CMAX);
    assign o_st.empty    = (r_count == '0);
    assign o_st.built    = r_built;
    assign o_st.i_last   = (r_i == r_count - 1'b1);
    assign o_st.mod_done = r_mod_done;
    assign o_st.ptr_end  = (r_ptr == nul) || (r_ptr >= r_count) || (r_steps >= r_count);
    assign o_st.name_eq  = names_eq(r_rd_name, r_key);
    assign o_st.match    = r_match;
    assign o_status = r_status;
    assign o_index  = r_index;
endmodule
`default_nettype wire
